>>> rtl/mbc_pkg.sv
// Shared types, constants and bank-wrap tables for the MBC1 bank controller.
// Used by the top level; has no dependencies of its own.
`default_nettype none

package mbc_pkg;

    // Cartridge geometry
    localparam int ROM_BANKS      = 32;
    localparam int RAM_BANK_COUNT = 4;
    localparam int ROM_BANK_BYTES = 16'h4000;
    localparam int RAM_BANK_BYTES = 16'h2000;
    localparam int ROM_BYTES      = ROM_BANKS * ROM_BANK_BYTES;
    localparam int RAM_BYTES      = RAM_BANK_COUNT * RAM_BANK_BYTES;
    localparam int ROM_BANK_W     = $clog2(ROM_BANKS);
    localparam int RAM_BANK_W     = (RAM_BANK_COUNT > 1) ? $clog2(RAM_BANK_COUNT) : 1;
    localparam int ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
    localparam int RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
    localparam int ROM_AW         = ROM_BANK_W + ROM_OFS_W;
    localparam int RAM_AW         = $clog2(RAM_BYTES);

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_ADDR_W = 19;
    localparam int IN_W       = 48;

    localparam logic [3:0]        RAM_EN_KEY = 4'hA;
    localparam logic [DATA_W-1:0] BLOCKED_BYTE = 8'hFF;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MBC1_ENABLED = 1'b0,
        CFG_RAM_PRESENT  = 1'b1
    } cfg_index_t;

    // Item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // 8 KiB regions of the bus, address[15:13]
    typedef enum logic [2:0] {
        REG_RAM_EN   = 3'd0,
        REG_ROM_BANK = 3'd1,
        REG_RAM_BANK = 3'd2,
        REG_MODE     = 3'd3,
        REG_VRAM     = 3'd4,
        REG_EXT_RAM  = 3'd5,
        REG_WRAM     = 3'd6,
        REG_HIGH     = 3'd7
    } region_t;

    // Where a read byte comes from
    typedef enum logic [1:0] {
        SRC_ROM     = 2'd0,
        SRC_RAM     = 2'd1,
        SRC_BLOCKED = 2'd2
    } read_src_t;

    // ROM bank number taken modulo ROM_BANKS (constant table)
    function automatic logic [ROM_BANK_W-1:0] rom_bank_wrap(input logic [5:0] bank);
        logic [ROM_BANK_W-1:0] r;
        r = '0;
        for (int k = 0; k < 64; k++) begin
            if (bank == 6'(k))
                r = ROM_BANK_W'(k % ROM_BANKS);
        end
        return r;
    endfunction

    // RAM bank number taken modulo RAM_BANK_COUNT (constant table)
    function automatic logic [RAM_BANK_W-1:0] ram_bank_wrap(input logic [1:0] bank);
        logic [RAM_BANK_W-1:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            if (bank == 2'(k))
                r = RAM_BANK_W'(k % RAM_BANK_COUNT);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/mbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read word when enabled
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/mbc1_bank_controller.sv
// MBC1 cartridge bank controller: bank registers, ROM and RAM stores, stream ports.
// Depends on mbc_pkg and mbc_ram.
`default_nettype none

// The controller takes one beat per cycle unless the input side stalls: bus
// reads, bus writes and ROM-load bytes, with the action carried on tuser. A bus
// read registers its store byte in the memory read stage, which moves it into
// the output register once that register is empty or its byte is being taken;
// writes and loads give no output beat. The input side stalls only when both
// the memory read stage and the output register hold a byte that the sink has
// not taken. ROM and RAM contents are undefined until loaded or written; there
// is no clearing pass, so the block is ready right after reset. Configuration
// writes are to be made only while the block is idle.

module mbc1_bank_controller (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_wr_en,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [0:0]                  cfg_data,
    // input stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] action
    input  wire logic [mbc_pkg::ACTION_W-1:0] s_axis_tuser,
    // [15:0] address, [23:16] data, [42:24] rom_address, [47:43] zero
    input  wire logic [mbc_pkg::IN_W-1:0]    s_axis_tdata,
    // output stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [7:0] read_data
    output logic      [mbc_pkg::DATA_W-1:0]  m_axis_tdata
);

    // Configuration registers
    logic mbc1_enabled_reg;
    logic ram_present_reg;

    // Bank state
    logic                   ram_enable_reg,  ram_enable_next;
    logic [4:0]             rom_bank_reg,    rom_bank_next;
    logic [1:0]             ram_bank_reg,    ram_bank_next;
    logic [1:0]             active_bank_reg, active_bank_next;
    logic                   mode_reg,        mode_next;

    // Read stage and output register
    logic                   s1_valid_reg,    s1_valid_next;
    mbc_pkg::read_src_t     s1_src_reg,      s1_src_next;
    logic                   out_valid_reg,   out_valid_next;
    logic [mbc_pkg::DATA_W-1:0] out_data_reg, out_data_next;

    // Input fields
    mbc_pkg::action_t                   action;
    logic [mbc_pkg::ADDR_W-1:0]         address;
    logic [mbc_pkg::DATA_W-1:0]         data;
    logic [mbc_pkg::ROM_ADDR_W-1:0]     rom_address;
    mbc_pkg::region_t                   region;

    logic                   accept;
    logic                   s1_advance;
    logic                   ram_ok;

    // Memory ports
    logic                               rom_we, rom_re;
    logic [mbc_pkg::ROM_AW-1:0]         rom_waddr, rom_raddr;
    logic [mbc_pkg::DATA_W-1:0]         rom_rdata;
    logic                               ram_we, ram_re;
    logic [mbc_pkg::RAM_AW-1:0]         ram_addr;
    logic [mbc_pkg::DATA_W-1:0]         ram_rdata;

    logic [mbc_pkg::ADDR_W-1:0]         bank_ofs;
    logic [5:0]                         rom_bank_raw;
    logic [mbc_pkg::RAM_BANK_W+mbc_pkg::RAM_OFS_W-1:0] ram_full_addr;

    // Unpack the beat
    assign action      = mbc_pkg::action_t'(s_axis_tuser);
    assign address     = s_axis_tdata[15:0];
    assign data        = s_axis_tdata[23:16];
    assign rom_address = s_axis_tdata[42:24];
    assign region      = mbc_pkg::region_t'(address[15:13]);

    // Handshake: take a beat unless the read stage is stuck behind a full output
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ram_ok = ram_enable_reg && ram_present_reg;

    // Address generation for both stores
    always_comb
    begin
        bank_ofs = address - 16'(mbc_pkg::ROM_BANK_BYTES);
        if (!mbc1_enabled_reg || address < 16'(mbc_pkg::ROM_BANK_BYTES))
            rom_bank_raw = {4'b0, address[15:14]};
        else
            rom_bank_raw = {1'b0, rom_bank_reg} + {4'b0, bank_ofs[15:14]};
        rom_raddr = {mbc_pkg::rom_bank_wrap(rom_bank_raw), address[13:0]};
        rom_waddr = {mbc_pkg::rom_bank_wrap({1'b0, rom_address[18:14]}), rom_address[13:0]};
        ram_full_addr = {mbc_pkg::ram_bank_wrap(active_bank_reg),
                         address[mbc_pkg::RAM_OFS_W-1:0]};
        ram_addr = ram_full_addr[mbc_pkg::RAM_AW-1:0];
    end

    // Decode the accepted beat: register updates, store accesses, read source
    always_comb
    begin
        ram_enable_next  = ram_enable_reg;
        rom_bank_next    = rom_bank_reg;
        ram_bank_next    = ram_bank_reg;
        active_bank_next = active_bank_reg;
        mode_next        = mode_reg;
        rom_we = 1'b0;
        rom_re = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        s1_src_next = s1_src_reg;

        if (accept) begin
            case (action)
                mbc_pkg::ACT_READ:
                begin
                    if (mbc1_enabled_reg && region == mbc_pkg::REG_EXT_RAM) begin
                        if (ram_ok) begin
                            ram_re      = 1'b1;
                            s1_src_next = mbc_pkg::SRC_RAM;
                        end else begin
                            s1_src_next = mbc_pkg::SRC_BLOCKED;
                        end
                    end else begin
                        rom_re      = 1'b1;
                        s1_src_next = mbc_pkg::SRC_ROM;
                    end
                end
                mbc_pkg::ACT_WRITE:
                begin
                    if (mbc1_enabled_reg) begin
                        case (region)
                            mbc_pkg::REG_RAM_EN:
                                ram_enable_next = (data[3:0] == mbc_pkg::RAM_EN_KEY);
                            mbc_pkg::REG_ROM_BANK:
                                rom_bank_next = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
                            mbc_pkg::REG_RAM_BANK:
                            begin
                                ram_bank_next = data[1:0];
                                if (mode_reg)
                                    active_bank_next = data[1:0];
                            end
                            mbc_pkg::REG_MODE:
                            begin
                                mode_next = data[0];
                                if (data[0])
                                    active_bank_next = ram_bank_reg;
                            end
                            mbc_pkg::REG_EXT_RAM:
                                ram_we = ram_ok;
                            default:
                                ;
                        endcase
                    end
                end
                mbc_pkg::ACT_LOAD:
                    rom_we = 1'b1;
                default:
                    ;
            endcase
        end
    end

    // Read stage and output register
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (s1_advance) begin
            out_valid_next = 1'b1;
            case (s1_src_reg)
                mbc_pkg::SRC_ROM: out_data_next = rom_rdata;
                mbc_pkg::SRC_RAM: out_data_next = ram_rdata;
                default:          out_data_next = mbc_pkg::BLOCKED_BYTE;
            endcase
            s1_valid_next = 1'b0;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        if (accept && action == mbc_pkg::ACT_READ)
            s1_valid_next = 1'b1;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mbc1_enabled_reg <= 1'b1;
            ram_present_reg  <= 1'b1;
            ram_enable_reg   <= 1'b0;
            rom_bank_reg     <= 5'd1;
            ram_bank_reg     <= 2'd0;
            active_bank_reg  <= 2'd0;
            mode_reg         <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (mbc_pkg::cfg_index_t'(cfg_index))
                    mbc_pkg::CFG_MBC1_ENABLED: mbc1_enabled_reg <= cfg_data[0];
                    mbc_pkg::CFG_RAM_PRESENT:  ram_present_reg  <= cfg_data[0];
                    default:                   ;
                endcase
            end
            ram_enable_reg  <= ram_enable_next;
            rom_bank_reg    <= rom_bank_next;
            ram_bank_reg    <= ram_bank_next;
            active_bank_reg <= active_bank_next;
            mode_reg        <= mode_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_src_reg   <= s1_src_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Stores; a write lands at the edge before any later read is issued
    mbc_ram #(
        .WIDTH (mbc_pkg::DATA_W),
        .DEPTH (mbc_pkg::ROM_BYTES)
    ) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .waddr (rom_waddr),
        .wdata (data),
        .re    (rom_re),
        .raddr (rom_raddr),
        .rdata (rom_rdata)
    );

    mbc_ram #(
        .WIDTH (mbc_pkg::DATA_W),
        .DEPTH (mbc_pkg::RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (data),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // A beat taken while a byte sits in the read stage must move that byte on
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> s1_advance)
        else $error("read stage overwritten");

    // An accepted read always occupies the read stage next cycle
    a_read_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == mbc_pkg::ACT_READ) |=> s1_valid_reg)
        else $error("accepted read lost");

    // Writes and loads never create an output byte
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action != mbc_pkg::ACT_READ && !s1_valid_reg) |=> !s1_valid_reg)
        else $error("result from a non-read beat");

    // The ROM bank register never holds zero
    a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rom_bank_reg != 5'd0)
        else $error("rom bank is zero");

endmodule

`default_nettype wire
